### src/dcp_pkg.sv
// shared types, constants and register map for the depth to coloured point unit
`timescale 1ns / 1ps

package dcp_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam int WIDTH_W  = 13;
    localparam int CENTER_W = 16;
    localparam int SCALE_W  = 32;
    localparam int DEPTH_W  = 16;
    localparam int HALF_W   = 16;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH = 13'd640;
    localparam logic [CENTER_W-1:0] RST_CENTER_COL  = 16'd5112;
    localparam logic [CENTER_W-1:0] RST_CENTER_ROW  = 16'd3832;
    localparam logic [SCALE_W-1:0]  RST_SCALE_H     = 32'd8181;
    localparam logic [SCALE_W-1:0]  RST_SCALE_V     = 32'd8181;
    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 32'd4294967;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_CENTER_COL  = 3'd1,
        REG_CENTER_ROW  = 3'd2,
        REG_SCALE_H     = 3'd3,
        REG_SCALE_V     = 3'd4,
        REG_DEPTH_SCALE = 3'd5,
        REG_COLOR_ORDER = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ORDER_RGB  = 2'd0,
        ORDER_BGR  = 2'd1,
        ORDER_MONO = 2'd2
    } t_color_order;

    typedef struct packed {
        logic [15:0] depth_sample;
        logic [7:0]  color_byte0;
        logic [7:0]  color_byte1;
        logic [7:0]  color_byte2;
        logic        frame_start;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic               point_valid;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_point;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_MAG_X = 4'd1,
        OP_MAG_Y = 4'd2,
        OP_Z_LO  = 4'd3,
        OP_Z_HI  = 4'd4,
        OP_X_LO  = 4'd5,
        OP_X_HI  = 4'd6,
        OP_Y_LO  = 4'd7,
        OP_Y_HI  = 4'd8
    } t_mul_op;

    typedef struct packed {
        logic    accept;
        t_mul_op op;
        logic    finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### src/dcp_stream_if.sv
// valid/ready stream channel carrying one request payload
`timescale 1ns / 1ps

interface dcp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/dcp_ctrl.sv
// sequencer: steps the shared multiplier through one pixel at a time
`timescale 1ns / 1ps

module dcp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  dcp_pkg::t_dp_status   i_status,
    output logic                  o_in_ready,
    output dcp_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MAG_X = 11'b00000000010,
        S_MAG_Y = 11'b00000000100,
        S_Z_LO  = 11'b00000001000,
        S_Z_HI  = 11'b00000010000,
        S_X_LO  = 11'b00000100000,
        S_X_HI  = 11'b00001000000,
        S_Y_LO  = 11'b00010000000,
        S_Y_HI  = 11'b00100000000,
        S_DRAIN = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.op     = dcp_pkg::OP_NONE;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MAG_X;
                end
            end
            S_MAG_X: begin
                o_cmd.op = dcp_pkg::OP_MAG_X;
                n_state  = S_MAG_Y;
            end
            S_MAG_Y: begin
                o_cmd.op = dcp_pkg::OP_MAG_Y;
                n_state  = S_Z_LO;
            end
            S_Z_LO: begin
                o_cmd.op = dcp_pkg::OP_Z_LO;
                n_state  = S_Z_HI;
            end
            S_Z_HI: begin
                o_cmd.op = dcp_pkg::OP_Z_HI;
                n_state  = S_X_LO;
            end
            S_X_LO: begin
                o_cmd.op = dcp_pkg::OP_X_LO;
                n_state  = S_X_HI;
            end
            S_X_HI: begin
                o_cmd.op = dcp_pkg::OP_X_HI;
                n_state  = S_Y_LO;
            end
            S_Y_LO: begin
                o_cmd.op = dcp_pkg::OP_Y_LO;
                n_state  = S_Y_HI;
            end
            S_Y_HI: begin
                o_cmd.op = dcp_pkg::OP_Y_HI;
                n_state  = S_DRAIN;
            end
            S_DRAIN: begin
                // last product is folded into the accumulator here
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_MAG_X)
        else $error("accepted request did not start the multiply sequence");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("result loaded while output register still held");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.accept)
        else $error("request accepted mid sequence");

endmodule

### src/dcp_datapath.sv
// registers, pixel counters, shared multiplier, accumulators and output register
`timescale 1ns / 1ps

module dcp_datapath #(
    parameter int COORD_BITS = dcp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dcp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dcp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  dcp_pkg::t_ctrl_cmd              i_cmd,
    input  dcp_pkg::t_pixel                 i_pixel,
    output dcp_pkg::t_dp_status             o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output dcp_pkg::t_point                 o_point
);

    localparam int POS16_W = COORD_BITS + 4;
    localparam int DIFF_W  = (POS16_W > dcp_pkg::CENTER_W) ? POS16_W : dcp_pkg::CENTER_W;
    localparam int MAG_W   = DIFF_W + dcp_pkg::DEPTH_W;
    localparam int PROD_W  = MAG_W + dcp_pkg::HALF_W;
    localparam int ACC_W   = 64;
    localparam int ZACC_W  = dcp_pkg::DEPTH_W + dcp_pkg::SCALE_W;
    localparam int CMP_W   = (COORD_BITS + 1 > dcp_pkg::WIDTH_W) ? COORD_BITS + 1
                                                                : dcp_pkg::WIDTH_W;
    localparam int FRAC_X  = 20;
    localparam int Q_W     = ACC_W - FRAC_X;

    // configuration registers
    logic [dcp_pkg::WIDTH_W-1:0]  r_width;
    logic [dcp_pkg::CENTER_W-1:0] r_center_col;
    logic [dcp_pkg::CENTER_W-1:0] r_center_row;
    logic [dcp_pkg::SCALE_W-1:0]  r_scale_h;
    logic [dcp_pkg::SCALE_W-1:0]  r_scale_v;
    logic [dcp_pkg::SCALE_W-1:0]  r_depth_scale;
    logic [1:0]                   r_color_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= dcp_pkg::RST_IMAGE_WIDTH;
            r_center_col  <= dcp_pkg::RST_CENTER_COL;
            r_center_row  <= dcp_pkg::RST_CENTER_ROW;
            r_scale_h     <= dcp_pkg::RST_SCALE_H;
            r_scale_v     <= dcp_pkg::RST_SCALE_V;
            r_depth_scale <= dcp_pkg::RST_DEPTH_SCALE;
            r_color_order <= dcp_pkg::ORDER_RGB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dcp_pkg::REG_IMAGE_WIDTH: r_width       <= i_cfg_data[dcp_pkg::WIDTH_W-1:0];
                dcp_pkg::REG_CENTER_COL:  r_center_col  <= i_cfg_data[dcp_pkg::CENTER_W-1:0];
                dcp_pkg::REG_CENTER_ROW:  r_center_row  <= i_cfg_data[dcp_pkg::CENTER_W-1:0];
                dcp_pkg::REG_SCALE_H:     r_scale_h     <= i_cfg_data;
                dcp_pkg::REG_SCALE_V:     r_scale_v     <= i_cfg_data;
                dcp_pkg::REG_DEPTH_SCALE: r_depth_scale <= i_cfg_data;
                dcp_pkg::REG_COLOR_ORDER: r_color_order <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // pixel position and per-pixel operands
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] col_cur;
    logic [COORD_BITS-1:0] row_cur;
    logic [COORD_BITS:0]   col_inc;
    logic                  row_wrap;
    logic [DIFF_W-1:0]     pos_x;
    logic [DIFF_W-1:0]     pos_y;
    logic [DIFF_W-1:0]     ctr_x;
    logic [DIFF_W-1:0]     ctr_y;

    logic [DIFF_W-1:0]            r_diff_x;
    logic [DIFF_W-1:0]            r_diff_y;
    logic                         r_neg_x;
    logic                         r_neg_y;
    logic [dcp_pkg::DEPTH_W-1:0]  r_depth;
    logic [7:0]                   r_red;
    logic [7:0]                   r_green;
    logic [7:0]                   r_blue;

    always_comb begin
        col_cur  = i_pixel.frame_start ? '0 : r_col;
        row_cur  = i_pixel.frame_start ? '0 : r_row;
        col_inc  = {1'b0, col_cur} + (COORD_BITS + 1)'(1);
        row_wrap = (CMP_W'(col_inc) >= CMP_W'(r_width)) || col_inc[COORD_BITS];
        pos_x    = DIFF_W'({col_cur, 4'b0000});
        pos_y    = DIFF_W'({row_cur, 4'b0000});
        ctr_x    = DIFF_W'(r_center_col);
        ctr_y    = DIFF_W'(r_center_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            r_col <= row_wrap ? '0 : col_inc[COORD_BITS-1:0];
            r_row <= row_cur + COORD_BITS'(row_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_neg_x  <= pos_x < ctr_x;
            r_neg_y  <= pos_y < ctr_y;
            r_diff_x <= (pos_x < ctr_x) ? ctr_x - pos_x : pos_x - ctr_x;
            r_diff_y <= (pos_y < ctr_y) ? ctr_y - pos_y : pos_y - ctr_y;
            r_depth  <= i_pixel.depth_sample;
            unique case (r_color_order)
                dcp_pkg::ORDER_RGB: begin
                    r_red   <= i_pixel.color_byte0;
                    r_green <= i_pixel.color_byte1;
                    r_blue  <= i_pixel.color_byte2;
                end
                dcp_pkg::ORDER_BGR: begin
                    r_red   <= i_pixel.color_byte2;
                    r_green <= i_pixel.color_byte1;
                    r_blue  <= i_pixel.color_byte0;
                end
                default: begin
                    r_red   <= i_pixel.color_byte0;
                    r_green <= i_pixel.color_byte0;
                    r_blue  <= i_pixel.color_byte0;
                end
            endcase
        end
    end

    // shared multiplier, product registered, folded in on the next cycle
    logic [MAG_W-1:0]           mul_a;
    logic [dcp_pkg::HALF_W-1:0] mul_b;
    logic [PROD_W-1:0]          r_prod;
    dcp_pkg::t_mul_op           r_wb_op;
    logic [MAG_W-1:0]           r_mag_x;
    logic [MAG_W-1:0]           r_mag_y;
    logic [ACC_W-1:0]           r_acc_x;
    logic [ACC_W-1:0]           r_acc_y;
    logic [ZACC_W-1:0]          r_acc_z;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            dcp_pkg::OP_MAG_X: begin
                mul_a = MAG_W'(r_diff_x);
                mul_b = r_depth;
            end
            dcp_pkg::OP_MAG_Y: begin
                mul_a = MAG_W'(r_diff_y);
                mul_b = r_depth;
            end
            dcp_pkg::OP_Z_LO: begin
                mul_a = MAG_W'(r_depth);
                mul_b = r_depth_scale[15:0];
            end
            dcp_pkg::OP_Z_HI: begin
                mul_a = MAG_W'(r_depth);
                mul_b = r_depth_scale[31:16];
            end
            dcp_pkg::OP_X_LO: begin
                mul_a = r_mag_x;
                mul_b = r_scale_h[15:0];
            end
            dcp_pkg::OP_X_HI: begin
                mul_a = r_mag_x;
                mul_b = r_scale_h[31:16];
            end
            dcp_pkg::OP_Y_LO: begin
                mul_a = r_mag_y;
                mul_b = r_scale_v[15:0];
            end
            dcp_pkg::OP_Y_HI: begin
                mul_a = r_mag_y;
                mul_b = r_scale_v[31:16];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_op <= dcp_pkg::OP_NONE;
        end else begin
            r_wb_op <= i_cmd.op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // accumulators wrap: x and y at 64 bits, z at 48 bits, as the projection is defined
    always_ff @(posedge i_clk) begin
        unique case (r_wb_op)
            dcp_pkg::OP_MAG_X: r_mag_x <= r_prod[MAG_W-1:0];
            dcp_pkg::OP_MAG_Y: r_mag_y <= r_prod[MAG_W-1:0];
            dcp_pkg::OP_Z_LO:  r_acc_z <= ZACC_W'(r_prod);
            dcp_pkg::OP_Z_HI:  r_acc_z <= r_acc_z + (ZACC_W'(r_prod) << dcp_pkg::HALF_W);
            dcp_pkg::OP_X_LO:  r_acc_x <= ACC_W'(r_prod);
            dcp_pkg::OP_X_HI:  r_acc_x <= r_acc_x + (ACC_W'(r_prod) << dcp_pkg::HALF_W);
            dcp_pkg::OP_Y_LO:  r_acc_y <= ACC_W'(r_prod);
            dcp_pkg::OP_Y_HI:  r_acc_y <= r_acc_y + (ACC_W'(r_prod) << dcp_pkg::HALF_W);
            default: ;
        endcase
    end

    // floor shift and saturation
    logic [Q_W-1:0] q_x;
    logic [Q_W-1:0] q_y;
    logic [Q_W:0]   qn_x;
    logic [Q_W:0]   qn_y;
    logic [31:0]    sat_x;
    logic [31:0]    sat_y;
    logic [31:0]    q_z;
    logic [30:0]    sat_z;
    logic           depth_ok;

    always_comb begin
        q_x  = r_acc_x[ACC_W-1:FRAC_X];
        q_y  = r_acc_y[ACC_W-1:FRAC_X];
        qn_x = {1'b0, q_x} + (Q_W + 1)'(|r_acc_x[FRAC_X-1:0]);
        qn_y = {1'b0, q_y} + (Q_W + 1)'(|r_acc_y[FRAC_X-1:0]);
        if (r_neg_x) begin
            sat_x = (qn_x > (Q_W + 1)'(33'h080000000)) ? 32'h80000000
                                                       : ~qn_x[31:0] + 32'd1;
        end else begin
            sat_x = (q_x > Q_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q_x[31:0];
        end
        if (r_neg_y) begin
            sat_y = (qn_y > (Q_W + 1)'(33'h080000000)) ? 32'h80000000
                                                       : ~qn_y[31:0] + 32'd1;
        end else begin
            sat_y = (q_y > Q_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q_y[31:0];
        end
        q_z      = r_acc_z[ZACC_W-1:dcp_pkg::HALF_W];
        sat_z    = q_z[31] ? 31'h7FFFFFFF : q_z[30:0];
        depth_ok = r_depth != '0;
    end

    // output register
    logic            r_out_valid;
    dcp_pkg::t_point r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.point_x     <= depth_ok ? sat_x : '0;
            r_out.point_y     <= depth_ok ? sat_y : '0;
            r_out.point_z     <= depth_ok ? sat_z : '0;
            r_out.point_valid <= depth_ok;
            r_out.red         <= r_red;
            r_out.green       <= r_green;
            r_out.blue        <= r_blue;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_point           = r_out;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.point_valid) |->
            (r_out.point_x == '0 && r_out.point_y == '0 && r_out.point_z == '0))
        else $error("invalid point carries non-zero coordinates");

    a_frame_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && i_pixel.frame_start && r_width > dcp_pkg::WIDTH_W'(1)) |=>
            (r_col == COORD_BITS'(1) && r_row == '0))
        else $error("frame start did not restart the raster position");

    a_finish_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_wb_op == dcp_pkg::OP_NONE)
        else $error("result loaded before the last product was folded in");

endmodule

### src/depth_to_colored_point_unit.sv
// top level: pinhole back-projection of a depth pixel stream into coloured points
//
//   channel   dir   handshake            payload
//   i_pixel   in    valid/ready          depth sample, three colour bytes, frame start
//   o_point   out   valid/ready          x, y, z (Q16.16 m), valid flag, red/green/blue
//   i_cfg_*   in    write enable only    register index and 32-bit data
//
// each pixel steps through accept, eight passes through the single shared 32x16
// multiplier, a drain step to fold in the last product, and a final step that loads
// the output register. the next pixel is taken while a result waits in the output
// register. a stalled output holds the sequencer in its final step.
// synchronous active-low reset restores the register defaults and zeroes the counters
`timescale 1ns / 1ps

module depth_to_colored_point_unit #(
    parameter int COORD_BITS = dcp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dcp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dcp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    dcp_stream_if.sink                      i_pixel,
    dcp_stream_if.source                    o_point
);

    dcp_pkg::t_ctrl_cmd  cmd;
    dcp_pkg::t_dp_status status;
    dcp_pkg::t_pixel     pixel;
    dcp_pkg::t_point     point;
    logic                in_ready;
    logic                out_valid;

    assign pixel = i_pixel.data;

    dcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pixel.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    dcp_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_pixel     (pixel),
        .o_status    (status),
        .i_out_ready (o_point.ready),
        .o_out_valid (out_valid),
        .o_point     (point)
    );

    assign i_pixel.ready = in_ready;
    assign o_point.valid = out_valid;
    assign o_point.data  = point;

endmodule
